FILE: hdl/pfee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfee_pkg;

   // field widths of the channels
   localparam int RAW_W    = 25;
   localparam int VERTEX_W = 24;
   localparam int COUNT_W  = 9;

   // decoded vertex numbers are kept to this many bits
   localparam int INDEX_BITS     = 24;
   // per-face edge count stops here
   localparam int MAX_FACE_EDGES = 256;

   localparam logic [VERTEX_W-1:0] VERT_MASK =
      (INDEX_BITS >= VERTEX_W) ? {VERTEX_W{1'b1}}
                               : VERTEX_W'((64'd1 << INDEX_BITS) - 64'd1);

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // result kind codes
   localparam logic KIND_EDGE  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // one accepted index as a work packet: one or two results
   typedef struct packed {
      logic                two;
      logic                kind;
      logic [VERTEX_W-1:0] start0;
      logic [VERTEX_W-1:0] end0;
      logic [COUNT_W-1:0]  discard;
      logic [VERTEX_W-1:0] start1;
      logic [VERTEX_W-1:0] end1;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   typedef enum logic [1:0] {
      ST_FIRST  = 2'b01,
      ST_SECOND = 2'b10
   } phase_type;

endpackage

`default_nettype wire

FILE: hdl/pfee_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pfee_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              accept,
   input  wire                              mode,
   input  wire signed [pfee_pkg::RAW_W-1:0] vertex_index,
   input  wire [pfee_pkg::VERTEX_W-1:0]     vertex_total,
   input  wire                              face_end,
   output pfee_pkg::push_type               push
);

   logic [pfee_pkg::VERTEX_W-1:0] first_ff, first_in;
   logic [pfee_pkg::VERTEX_W-1:0] prev_ff, prev_in;
   logic [pfee_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                          inside_ff, inside_in;
   logic                          skip_ff, skip_in;

   logic [pfee_pkg::RAW_W-1:0]    raw;
   logic [pfee_pkg::RAW_W-1:0]    mag;
   logic                          idx_ok;
   logic [pfee_pkg::VERTEX_W-1:0] vert;
   logic [pfee_pkg::VERTEX_W-1:0] first_eff;
   logic [pfee_pkg::COUNT_W-1:0]  count_inc;
   logic                          primary;
   logic                          closing;

   // index decode
   always_comb begin
      raw    = vertex_index;
      mag    = ~raw + pfee_pkg::RAW_W'(1);
      idx_ok = (raw != '0) && (!raw[pfee_pkg::RAW_W-1] || (mag <= {1'b0, vertex_total}));
      if (raw[pfee_pkg::RAW_W-1]) begin
         vert = (vertex_total - mag[pfee_pkg::VERTEX_W-1:0]) & pfee_pkg::VERT_MASK;
      end else begin
         vert = (raw[pfee_pkg::VERTEX_W-1:0] - pfee_pkg::VERTEX_W'(1)) & pfee_pkg::VERT_MASK;
      end
   end

   always_comb begin
      count_inc = (count_ff < pfee_pkg::COUNT_W'(pfee_pkg::MAX_FACE_EDGES))
                  ? count_ff + pfee_pkg::COUNT_W'(1) : count_ff;
      first_eff = inside_ff ? first_ff : vert;
      primary   = inside_ff || mode;
      closing   = face_end && !mode;

      first_in  = first_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      inside_in = inside_ff;
      skip_in   = skip_ff;

      push             = '0;
      push.job.kind    = pfee_pkg::KIND_EDGE;

      if (accept) begin
         if (skip_ff) begin
            if (face_end) begin
               inside_in = 1'b0;
               skip_in   = 1'b0;
               count_in  = '0;
            end
         end else if (!idx_ok) begin
            push.push        = 1'b1;
            push.job.kind    = pfee_pkg::KIND_ERROR;
            push.job.discard = count_ff;
            count_in         = '0;
            if (face_end) begin
               inside_in = 1'b0;
               skip_in   = 1'b0;
            end else begin
               skip_in = 1'b1;
            end
         end else begin
            first_in  = first_eff;
            inside_in = 1'b1;
            prev_in   = vert;
            if (primary) begin
               count_in = count_inc;
            end
            if (primary) begin
               push.push         = 1'b1;
               push.job.start0   = (inside_ff && !mode) ? prev_ff : vert;
               push.job.end0     = vert;
               push.job.two      = closing;
               push.job.start1   = first_eff;
               push.job.end1     = vert;
            end else if (closing) begin
               // single-index polygon face: closing self edge only
               push.push         = 1'b1;
               push.job.start0   = first_eff;
               push.job.end0     = vert;
            end
            if (face_end) begin
               inside_in = 1'b0;
               skip_in   = 1'b0;
               count_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         prev_ff   <= '0;
         count_ff  <= '0;
         inside_ff <= 1'b0;
         skip_ff   <= 1'b0;
      end else begin
         first_ff  <= first_in;
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         inside_ff <= inside_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pfee_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pfee_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire pfee_pkg::push_type push,
   input  wire                  pop,
   output pfee_pkg::head_type   head,
   output logic                 full
);

   pfee_pkg::job_type               slot_ff [pfee_pkg::QUEUE_DEPTH];
   logic [pfee_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pfee_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pfee_pkg::QCOUNT_W-1:0]   count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   always_comb begin
      full       = (count_ff == pfee_pkg::QCOUNT_W'(pfee_pkg::QUEUE_DEPTH));
      head.valid = (count_ff != '0);
      head.job   = slot_ff[rd_ptr_ff];
      do_push    = push.push && !full;
      do_pop     = pop && head.valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + pfee_pkg::PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + pfee_pkg::PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + pfee_pkg::QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - pfee_pkg::QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pfee_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pfee_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire pfee_pkg::head_type           head,
   output logic                              pop,
   output logic                              out_valid,
   input  wire                               out_stall,
   output logic                              out_kind,
   output logic [pfee_pkg::VERTEX_W-1:0]     out_start,
   output logic [pfee_pkg::VERTEX_W-1:0]     out_end,
   output logic [pfee_pkg::COUNT_W-1:0]      out_discard,
   output logic                              out_last
);

   pfee_pkg::phase_type             phase_ff, phase_in;
   logic                            valid_ff, valid_in;
   logic                            kind_ff, kind_in;
   logic [pfee_pkg::VERTEX_W-1:0]   start_ff, start_in;
   logic [pfee_pkg::VERTEX_W-1:0]   end_ff, end_in;
   logic [pfee_pkg::COUNT_W-1:0]    discard_ff, discard_in;
   logic                            last_ff, last_in;
   logic                            load;

   always_comb begin
      load       = !valid_ff || !out_stall;
      pop        = 1'b0;
      phase_in   = phase_ff;
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      discard_in = discard_ff;
      last_in    = last_ff;
      if (load) begin
         valid_in = head.valid;
         if (head.valid) begin
            case (phase_ff)
               pfee_pkg::ST_FIRST: begin
                  kind_in    = head.job.kind;
                  start_in   = head.job.start0;
                  end_in     = head.job.end0;
                  discard_in = head.job.discard;
                  last_in    = !head.job.two;
                  if (head.job.two) begin
                     phase_in = pfee_pkg::ST_SECOND;
                  end else begin
                     pop = 1'b1;
                  end
               end
               pfee_pkg::ST_SECOND: begin
                  kind_in    = pfee_pkg::KIND_EDGE;
                  start_in   = head.job.start1;
                  end_in     = head.job.end1;
                  discard_in = '0;
                  last_in    = 1'b1;
                  phase_in   = pfee_pkg::ST_FIRST;
                  pop        = 1'b1;
               end
               default: begin
                  phase_in = pfee_pkg::ST_FIRST;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pfee_pkg::ST_FIRST;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      start_ff   <= start_in;
      end_ff     <= end_in;
      discard_ff <= discard_in;
      last_ff    <= last_in;
   end

   assign out_valid   = valid_ff;
   assign out_kind    = kind_ff;
   assign out_start   = start_ff;
   assign out_end     = end_ff;
   assign out_discard = discard_ff;
   assign out_last    = last_ff;

endmodule

`default_nettype wire

FILE: hdl/polygon_face_edge_emitter_unit.sv
// channel    direction  handshake            payload
// req_       in         req_valid/req_stall  mode, vertex_index, vertex_total, face_end
// rsp_       out        rsp_valid/rsp_stall  kind, edge_start, edge_end, discard_count, run_last
//
// one index transaction is taken per cycle while the four-entry job queue has room
// the back end drains one result per cycle while rsp_stall is low, so an index with a closing
// edge emits two results; a polygon face's silent first index pays for its closing edge, so whole
// faces run at one index per cycle; rsp_stall and faces that emit more results than indices slow it
// an index transaction's results pass through a queue slot and then the output register
// reset is synchronous and clears face state, queue pointers and the output valid
// req_stall rises only when the queue is full; rsp_stall freezes the output register while it is valid
`timescale 1ns / 1ps
`default_nettype none

module polygon_face_edge_emitter_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   // index transactions
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_mode,
   input  wire signed [pfee_pkg::RAW_W-1:0]    req_vertex_index,
   input  wire [pfee_pkg::VERTEX_W-1:0]        req_vertex_total,
   input  wire                                 req_face_end,
   // result transactions
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_kind,
   output logic [pfee_pkg::VERTEX_W-1:0]       rsp_edge_start,
   output logic [pfee_pkg::VERTEX_W-1:0]       rsp_edge_end,
   output logic [pfee_pkg::COUNT_W-1:0]        rsp_discard_count,
   output logic                                rsp_run_last
);

   pfee_pkg::push_type q_push;
   pfee_pkg::head_type q_head;
   logic               q_pop;
   logic               q_full;
   logic               req_accept;

   // front takes the index whenever the queue can hold its job
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   // front: decode, validate and track face state, build the job
   pfee_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .mode         (req_mode),
      .vertex_index (req_vertex_index),
      .vertex_total (req_vertex_total),
      .face_end     (req_face_end),
      .push         (q_push)
   );

   // queue of pending jobs
   pfee_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .head  (q_head),
      .full  (q_full)
   );

   // back: splits each job into its one or two result transactions
   pfee_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .pop         (q_pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_kind    (rsp_kind),
      .out_start   (rsp_edge_start),
      .out_end     (rsp_edge_end),
      .out_discard (rsp_discard_count),
      .out_last    (rsp_run_last)
   );

   // a job never lands in a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_full)
      else $error("job pushed into full queue");

   // the second result of a pair is ready right behind the first
   a_pair_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |=> rsp_valid)
      else $error("gap inside a result pair");

   // an error is a lone result with no edge
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == pfee_pkg::KIND_ERROR) |->
         rsp_run_last && (rsp_edge_start == '0) && (rsp_edge_end == '0))
      else $error("malformed error result");

   // edges never ask for a discard
   a_edge_no_discard: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == pfee_pkg::KIND_EDGE) |-> (rsp_discard_count == '0))
      else $error("edge result with discard count");

endmodule

`default_nettype wire

FILE: tb/pfee_result_check.sv
`timescale 1ns / 1ps

module pfee_result_check (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire                               req_stall,
   input  wire                               req_mode,
   input  wire signed [pfee_pkg::RAW_W-1:0]  req_vertex_index,
   input  wire [pfee_pkg::VERTEX_W-1:0]      req_vertex_total,
   input  wire                               req_face_end,
   input  wire                               rsp_valid,
   input  wire                               rsp_stall,
   input  wire                               rsp_kind,
   input  wire [pfee_pkg::VERTEX_W-1:0]      rsp_edge_start,
   input  wire [pfee_pkg::VERTEX_W-1:0]      rsp_edge_end,
   input  wire [pfee_pkg::COUNT_W-1:0]       rsp_discard_count,
   input  wire                               rsp_run_last,
   output int                                fail_count,
   output int                                pending,
   output int                                edges_seen,
   output int                                errors_seen
);

   typedef struct packed {
      logic                          kind;
      logic [pfee_pkg::VERTEX_W-1:0] start_v;
      logic [pfee_pkg::VERTEX_W-1:0] end_v;
      logic [pfee_pkg::COUNT_W-1:0]  discard;
      logic                          last;
   } face_result_type;

   face_result_type edges_due[$];

   // face tracking state
   logic [pfee_pkg::VERTEX_W-1:0] first_vtx;
   logic [pfee_pkg::VERTEX_W-1:0] prev_vtx;
   logic [pfee_pkg::COUNT_W-1:0]  face_edges;
   logic                          in_face;
   logic                          skipping;

   int mismatches  = 0;
   int edge_total  = 0;
   int error_total = 0;

   initial begin
      fail_count  = 0;
      pending     = 0;
      edges_seen  = 0;
      errors_seen = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 25)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // one-based raw index to zero-based vertex, zero and over-deep negatives are bad
   function automatic logic decode_vertex(input logic [pfee_pkg::RAW_W-1:0] raw,
                                          input logic [pfee_pkg::VERTEX_W-1:0] total,
                                          output logic [pfee_pkg::VERTEX_W-1:0] vert);
      logic [pfee_pkg::RAW_W-1:0] depth;
      vert = '0;
      if (raw == '0)
         return 1'b0;
      if (raw[pfee_pkg::RAW_W-1]) begin
         depth = pfee_pkg::RAW_W'(0) - raw;
         if (depth > {1'b0, total})
            return 1'b0;
         vert = (total - depth[pfee_pkg::VERTEX_W-1:0]) & pfee_pkg::VERT_MASK;
      end else begin
         vert = (raw[pfee_pkg::VERTEX_W-1:0] - 1'b1) & pfee_pkg::VERT_MASK;
      end
      return 1'b1;
   endfunction

   task automatic close_face();
      in_face    = 1'b0;
      skipping   = 1'b0;
      face_edges = '0;
   endtask

   task automatic bump_edges();
      if (face_edges < pfee_pkg::MAX_FACE_EDGES)
         face_edges = face_edges + 1'b1;
   endtask

   task automatic predict_face_index(input logic pmode,
                                     input logic [pfee_pkg::RAW_W-1:0] raw,
                                     input logic [pfee_pkg::VERTEX_W-1:0] total,
                                     input logic fend);
      logic [pfee_pkg::VERTEX_W-1:0] v;
      face_result_type               res[2];
      int                            n;
      n = 0;
      if (skipping) begin
         if (fend)
            close_face();
         return;
      end
      if (!decode_vertex(raw, total, v)) begin
         edges_due.push_back('{pfee_pkg::KIND_ERROR, '0, '0, face_edges, 1'b1});
         if (fend) begin
            close_face();
         end else begin
            skipping   = 1'b1;
            face_edges = '0;
         end
         return;
      end
      if (!in_face) begin
         first_vtx = v;
         in_face   = 1'b1;
         if (pmode) begin
            res[n] = '{pfee_pkg::KIND_EDGE, v, v, '0, 1'b0};
            n = n + 1;
            bump_edges();
         end
      end else if (pmode) begin
         res[n] = '{pfee_pkg::KIND_EDGE, v, v, '0, 1'b0};
         n = n + 1;
         bump_edges();
      end else begin
         res[n] = '{pfee_pkg::KIND_EDGE, prev_vtx, v, '0, 1'b0};
         n = n + 1;
         bump_edges();
      end
      prev_vtx = v;
      if (fend) begin
         if (!pmode) begin
            res[n] = '{pfee_pkg::KIND_EDGE, first_vtx, v, '0, 1'b0};
            n = n + 1;
         end
         close_face();
      end
      if (n > 0)
         res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
         edges_due.push_back(res[i]);
   endtask

   task automatic check_result();
      face_result_type want;
      if (edges_due.size() == 0) begin
         report_mismatch($sformatf("result with nothing pending (kind %0d)", rsp_kind));
         return;
      end
      want = edges_due.pop_front();
      if (rsp_kind == pfee_pkg::KIND_ERROR)
         error_total++;
      else
         edge_total++;
      if (rsp_kind !== want.kind)
         report_mismatch($sformatf("kind got %0d want %0d", rsp_kind, want.kind));
      if (rsp_edge_start !== want.start_v)
         report_mismatch($sformatf("edge_start got %0d want %0d",
                                   rsp_edge_start, want.start_v));
      if (rsp_edge_end !== want.end_v)
         report_mismatch($sformatf("edge_end got %0d want %0d", rsp_edge_end, want.end_v));
      if (rsp_discard_count !== want.discard)
         report_mismatch($sformatf("discard_count got %0d want %0d",
                                   rsp_discard_count, want.discard));
      if (rsp_run_last !== want.last)
         report_mismatch($sformatf("run_last got %0d want %0d", rsp_run_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_vtx = '0;
         prev_vtx  = '0;
         close_face();
         edges_due.delete();
      end else begin
         // results leave before the index that is taken on the same edge
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            predict_face_index(req_mode, req_vertex_index, req_vertex_total, req_face_end);
      end
      pending     <= edges_due.size();
      fail_count  <= mismatches;
      edges_seen  <= edge_total;
      errors_seen <= error_total;
   end

endmodule

FILE: tb/polygon_face_edge_emitter_unit_tb.sv
`timescale 1ns / 1ps

module polygon_face_edge_emitter_unit_tb;

   import pfee_pkg::*;

   // timeout: slowest run is ~950 items x (long sender gap + two results behind long stalls)
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 950;
   // receiver hold-off long enough to fill the job queue many times over
   localparam int LONG_HOLD = 300;
   // drain time after the last expected result, well past the result latency
   localparam int TAIL_CYCLES = 16;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_mode         = 1'b0;
   logic signed [RAW_W-1:0]    req_vertex_index = '0;
   logic [VERTEX_W-1:0]        req_vertex_total = '0;
   logic                       req_face_end     = 1'b0;
   logic                       rsp_stall        = 1'b0;

   wire                        req_stall;
   wire                        rsp_valid;
   wire                        rsp_kind;
   wire [VERTEX_W-1:0]         rsp_edge_start;
   wire [VERTEX_W-1:0]         rsp_edge_end;
   wire [COUNT_W-1:0]          rsp_discard_count;
   wire                        rsp_run_last;

   int fail_count;
   int pending;
   int edges_seen;
   int errors_seen;

   int cycle_count       = 0;
   int items_sent        = 0;
   int faces_sent        = 0;
   int input_held_cycles = 0;

   // no-idle stretch on the sending side
   logic burst     = 1'b0;
   // handshake between sender and receiver for the long hold-off
   logic hold_req  = 1'b0;
   logic hold_done = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   polygon_face_edge_emitter_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_vertex_index  (req_vertex_index),
      .req_vertex_total  (req_vertex_total),
      .req_face_end      (req_face_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_edge_start    (rsp_edge_start),
      .rsp_edge_end      (rsp_edge_end),
      .rsp_discard_count (rsp_discard_count),
      .rsp_run_last      (rsp_run_last)
   );

   // watches both channels, predicts every result and compares in order
   pfee_result_check u_result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_vertex_index  (req_vertex_index),
      .req_vertex_total  (req_vertex_total),
      .req_face_end      (req_face_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_edge_start    (rsp_edge_start),
      .rsp_edge_end      (rsp_edge_end),
      .rsp_discard_count (rsp_discard_count),
      .rsp_run_last      (rsp_run_last),
      .fail_count        (fail_count),
      .pending           (pending),
      .edges_seen        (edges_seen),
      .errors_seen       (errors_seen)
   );

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
         $display("polygon_face_edge_emitter_unit_tb: FAIL");
         $finish;
      end
   end

   // idle length between transactions: mostly none or short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // raw one-based index, mostly well formed for the given vertex total
   function automatic logic [RAW_W-1:0] pick_index(input logic [VERTEX_W-1:0] tot);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return '0;
      else if (r < 9)
         return RAW_W'($urandom);
      else if (tot == 0 || (r >= 45 && r < 50))
         return RAW_W'($urandom_range(1, 16777215));
      else if (r < 45)
         return RAW_W'($urandom_range(1, tot));
      else
         return RAW_W'(0) - RAW_W'($urandom_range(1, tot));
   endfunction

   // offer one index transaction and wait until the block takes it;
   // valid stays high across back-to-back transactions
   task automatic send_index(input logic m, input logic [RAW_W-1:0] idx,
                             input logic [VERTEX_W-1:0] tot, input logic fend);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= m;
      req_vertex_index <= idx;
      req_vertex_total <= tot;
      req_face_end     <= fend;
      @(posedge clock);
      while (req_stall) begin
         input_held_cycles++;
         @(posedge clock);
      end
      items_sent++;
      if (fend)
         faces_sent++;
   endtask

   // receiver: random stall runs, plus one long hold-off on request
   initial begin : rsp_side
      int r;
      int n;
      logic s;
      forever begin
         if (hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               s = 1'b0;
               n = 100;
            end else if (r < 58) begin
               s = 1'b0;
               n = $urandom_range(1, 8);
            end else if (r < 86) begin
               s = 1'b1;
               n = $urandom_range(1, 3);
            end else if (r < 98) begin
               s = 1'b1;
               n = $urandom_range(4, 12);
            end else begin
               s = 1'b1;
               n = $urandom_range(20, 50);
            end
            rsp_stall <= s;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin : req_side
      int                  r;
      int                  len;
      logic                face_mode;
      logic                mixed;
      logic [VERTEX_W-1:0] tot;
      logic                sat_done;
      sat_done = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: polygon face with positive and negative indices, closing edge
      send_index(1'b0, 25'sd1, 24'd10, 1'b0);
      send_index(1'b0, 25'sd2, 24'd10, 1'b0);
      send_index(1'b0, -25'sd1, 24'd10, 1'b1);
      // bad first index (zero) on a face_end item
      send_index(1'b0, 25'sd0, 24'd10, 1'b1);
      // one-index polygon face closes on itself
      send_index(1'b0, 25'sd5, 24'd10, 1'b1);
      // point list: largest positive index with no vertices yet, deepest valid negative
      send_index(1'b1, 25'sd16777215, 24'd0, 1'b0);
      send_index(1'b1, -25'sd16777215, 24'd16777215, 1'b0);
      // most negative index is always too deep, rest of the face is skipped
      send_index(1'b1, -25'sd16777216, 24'd16777215, 1'b0);
      send_index(1'b0, 25'sd3, 24'd10, 1'b0);
      send_index(1'b1, 25'sd4, 24'd10, 1'b1);
      // mode changes within a face, error lands on face_end
      send_index(1'b0, -25'sd10, 24'd10, 1'b0);
      send_index(1'b1, 25'sd7, 24'd10, 1'b0);
      send_index(1'b0, 25'sd8, 24'd10, 1'b0);
      send_index(1'b0, -25'sd11, 24'd10, 1'b1);
      // single point face, then point start with polygon end
      send_index(1'b1, 25'sd1, 24'd1, 1'b1);
      send_index(1'b1, 25'sd2, 24'd5, 1'b0);
      send_index(1'b0, 25'sd3, 24'd5, 1'b1);
      // polygon start, point end: no closing edge
      send_index(1'b0, 25'sd9, 24'd20, 1'b0);
      send_index(1'b1, 25'sd10, 24'd20, 1'b1);
      // negative index with an empty model
      send_index(1'b0, -25'sd1, 24'd0, 1'b1);
      // error after a silent first index, then the skipped face ends
      send_index(1'b0, 25'sd1, 24'd0, 1'b0);
      send_index(1'b0, 25'sd0, 24'd0, 1'b0);
      send_index(1'b0, 25'sd0, 24'd0, 1'b1);

      // random part; the receiver holds off early while indices keep coming
      hold_req = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (!sat_done && items_sent > 400) begin
            // long point face drives the edge count into saturation, then an error
            sat_done = 1'b1;
            for (int i = 0; i < 260; i++)
               send_index(1'b1, RAW_W'($urandom_range(1, 1000)), 24'd1000, 1'b0);
            send_index(1'b0, 25'sd0, 24'd1000, 1'b0);
            send_index(1'b0, 25'sd1, 24'd1000, 1'b0);
            send_index(1'b1, 25'sd2, 24'd1000, 1'b1);
         end else if (r < 8) begin
            // noise: anything goes, face_end included
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               send_index(1'($urandom), RAW_W'($urandom), VERTEX_W'($urandom),
                          1'($urandom));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15)
               len = 1;
            else if (r < 80)
               len = $urandom_range(2, 6);
            else if (r < 95)
               len = $urandom_range(7, 16);
            else
               len = $urandom_range(17, 40);
            face_mode = 1'($urandom);
            mixed     = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 7)
               tot = VERTEX_W'($urandom_range(0, 1000));
            else
               tot = VERTEX_W'($urandom);
            for (int i = 0; i < len; i++)
               send_index(mixed ? 1'($urandom) : face_mode, pick_index(tot), tot,
                          i == len - 1);
         end
         // occasionally switch to or from a stretch without sender gaps
         if ($urandom_range(0, 9) == 0)
            burst = !burst;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d index transactions over %0d faces: %0d edges, %0d error results",
               items_sent, faces_sent, edges_seen, errors_seen);
      $display("input held off for %0d cycles, %0d mismatches", input_held_cycles,
               fail_count);
      if (fail_count == 0)
         $display("polygon_face_edge_emitter_unit_tb: PASS");
      else
         $display("polygon_face_edge_emitter_unit_tb: FAIL");
      $finish;
   end

endmodule
